@@ rtl/core/npcm_pkg.sv @@
package npcm_pkg;

    // default number of palette slots
    localparam int PALETTE_DEPTH_DEF = 256;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // word widths
    localparam int COLOR_W = 8;
    localparam int SLOT_W  = 8;
    localparam int COUNT_W = 9;
    localparam int DIST_W  = 18;
    localparam int BEST_W  = 20;
    localparam int SUM_W   = 10;

    // running best starts here, so the first entry always wins
    localparam logic [BEST_W-1:0] START_DIST = BEST_W'(999999);

    // grayscale fallback: (r+g+b)/3/3 == (r+g+b)/9, done as a reciprocal multiply
    localparam int GRAY_DIV    = 3;
    localparam int GRAY_DIV_SQ = GRAY_DIV * GRAY_DIV;
    localparam int GRAY_SHIFT  = 13;
    localparam int GRAY_RECIP  = (1 << GRAY_SHIFT) / GRAY_DIV_SQ + 1;
    localparam int GRAY_PROD_W = GRAY_SHIFT + COLOR_W;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_IDX_PALETTE_COUNT = 1'b0;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                 kind;
        logic [SLOT_W-1:0]    slot;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
    } npcm_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } back_state_t;

endpackage

@@ rtl/core/npcm_if.sv @@
interface npcm_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (
        output valid,
        output command,
        output entry_index,
        output red,
        output green,
        output blue,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  entry_index,
        input  red,
        input  green,
        input  blue,
        output ready
    );
endinterface

interface npcm_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  palette_index;
    logic [17:0] color_distance;

    modport source (
        output valid,
        output palette_index,
        output color_distance,
        input  ready
    );

    modport sink (
        input  valid,
        input  palette_index,
        input  color_distance,
        output ready
    );
endinterface

@@ rtl/core/npcm_front.sv @@
module npcm_front
    import npcm_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    npcm_in_if.sink    pixel_in,
    output npcm_op_t   head_op,
    output logic       head_valid,
    input  logic       head_pop
);

    npcm_op_t            q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;

    npcm_op_t            in_op;
    logic                in_drop;
    logic                accept;
    logic                push;
    logic                pop;

    // classify: loads beyond the palette are dropped here
    always_comb
    begin
        in_op.kind  = cmd_t'(pixel_in.command);
        in_op.slot  = pixel_in.entry_index;
        in_op.red   = pixel_in.red;
        in_op.green = pixel_in.green;
        in_op.blue  = pixel_in.blue;
        in_drop     = (in_op.kind == CMD_LOAD) &&
                      ({1'b0, pixel_in.entry_index} >= COUNT_W'(PALETTE_DEPTH));
    end

    assign pixel_in.ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign accept         = pixel_in.valid && pixel_in.ready;
    assign push           = accept && !in_drop;
    assign head_valid     = (count_reg != '0);
    assign pop            = head_pop && head_valid;
    assign head_op        = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + (QPTR_W + 1)'(1);
            2'b01:   count_next = count_reg - (QPTR_W + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_op;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg == rd_ptr_reg + QPTR_W'(count_reg))
        else $error("queue pointers disagree with fill count");

    a_drop_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_drop && !pop) |=> (count_reg == $past(count_reg)))
        else $error("dropped load entered the queue");
`endif

endmodule

@@ rtl/core/npcm_back.sv @@
module npcm_back
    import npcm_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] palette_count,
    input  npcm_op_t           head_op,
    input  logic               head_valid,
    output logic               head_pop,
    npcm_out_if.source         pixel_out
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW = $clog2(PALETTE_DEPTH + 1);

    function automatic logic [2*COLOR_W-1:0] sq_diff(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b
    );
        logic [COLOR_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return (2*COLOR_W)'(d) * (2*COLOR_W)'(d);
    endfunction

    logic [3*COLOR_W-1:0] palette_mem [PALETTE_DEPTH];

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [AW-1:0]        scan_cnt_reg;
    logic [AW-1:0]        scan_cnt_next;
    logic [CW-1:0]        cnt_eff;

    logic [COLOR_W-1:0]   pix_r_reg;
    logic [COLOR_W-1:0]   pix_g_reg;
    logic [COLOR_W-1:0]   pix_b_reg;

    // read stage
    logic                 rd_vld_reg;
    logic                 rd_last_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic [3*COLOR_W-1:0] rd_data_reg;

    // distance stage
    logic                 dist_vld_reg;
    logic                 dist_last_reg;
    logic [AW-1:0]        dist_idx_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic [DIST_W-1:0]    dist_next;

    logic [BEST_W-1:0]    best_dist_reg;
    logic [AW-1:0]        best_idx_reg;
    logic [BEST_W-1:0]    cand_dist;
    logic [AW-1:0]        cand_idx;

    logic                 out_vld_reg;
    logic [7:0]           out_idx_reg;
    logic [DIST_W-1:0]    out_dist_reg;
    logic                 out_free;

    logic                 mem_we;
    logic                 rd_issue;
    logic                 rd_last;
    logic                 start_pix;
    logic                 gray_set;
    logic                 scan_done;

    logic [SUM_W-1:0]       gray_sum;
    logic [GRAY_PROD_W-1:0] gray_prod;
    logic [7:0]             gray_val;

    assign cnt_eff = (palette_count > COUNT_W'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                              : palette_count[CW-1:0];
    assign out_free = !out_vld_reg || pixel_out.ready;
    assign rd_last  = ((CW'(scan_cnt_reg) + CW'(1)) == cnt_eff);

    // grayscale fallback
    assign gray_sum  = SUM_W'(head_op.red) + SUM_W'(head_op.green) + SUM_W'(head_op.blue);
    assign gray_prod = GRAY_PROD_W'(gray_sum) * GRAY_PROD_W'(GRAY_RECIP);
    assign gray_val  = gray_prod[GRAY_SHIFT +: 8];

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        head_pop      = 1'b0;
        mem_we        = 1'b0;
        rd_issue      = 1'b0;
        start_pix     = 1'b0;
        gray_set      = 1'b0;
        scan_done     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head_op.kind == CMD_LOAD)
                    begin
                        head_pop = 1'b1;
                        mem_we   = 1'b1;
                    end
                    else if (out_free)
                    begin
                        head_pop = 1'b1;
                        if (cnt_eff == '0)
                        begin
                            gray_set = 1'b1;
                        end
                        else
                        begin
                            start_pix     = 1'b1;
                            scan_cnt_next = '0;
                            state_next    = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                rd_issue = 1'b1;
                if (rd_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + AW'(1);
                end
            end
            ST_FINISH:
            begin
                if (dist_vld_reg && dist_last_reg)
                begin
                    scan_done  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // strict less-than keeps the lowest index on a tie
    always_comb
    begin
        cand_dist = best_dist_reg;
        cand_idx  = best_idx_reg;
        if (dist_vld_reg && (BEST_W'(dist_reg) < best_dist_reg))
        begin
            cand_dist = BEST_W'(dist_reg);
            cand_idx  = dist_idx_reg;
        end
    end

    assign dist_next = DIST_W'(sq_diff(pix_r_reg, rd_data_reg[23:16]))
                     + DIST_W'(sq_diff(pix_g_reg, rd_data_reg[15:8]))
                     + DIST_W'(sq_diff(pix_b_reg, rd_data_reg[7:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            dist_vld_reg  <= 1'b0;
            dist_last_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_issue;
            rd_last_reg   <= rd_issue && rd_last;
            dist_vld_reg  <= rd_vld_reg;
            dist_last_reg <= rd_vld_reg && rd_last_reg;
            if (gray_set || scan_done)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (pixel_out.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_cnt_reg <= scan_cnt_next;
        if (start_pix)
        begin
            pix_r_reg     <= head_op.red;
            pix_g_reg     <= head_op.green;
            pix_b_reg     <= head_op.blue;
            best_dist_reg <= START_DIST;
            best_idx_reg  <= '0;
        end
        else if (dist_vld_reg)
        begin
            best_dist_reg <= cand_dist;
            best_idx_reg  <= cand_idx;
        end
        rd_idx_reg   <= scan_cnt_reg;
        dist_idx_reg <= rd_idx_reg;
        dist_reg     <= dist_next;
        if (gray_set)
        begin
            out_idx_reg  <= gray_val;
            out_dist_reg <= '0;
        end
        else if (scan_done)
        begin
            out_idx_reg  <= 8'(cand_idx);
            out_dist_reg <= cand_dist[DIST_W-1:0];
        end
    end

    // palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            palette_mem[head_op.slot[AW-1:0]] <= {head_op.red, head_op.green, head_op.blue};
        end
        if (rd_issue)
        begin
            rd_data_reg <= palette_mem[scan_cnt_reg];
        end
    end

    assign pixel_out.valid          = out_vld_reg;
    assign pixel_out.palette_index  = out_idx_reg;
    assign pixel_out.color_distance = out_dist_reg;

`ifndef SYNTHESIS
    a_scan_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !out_vld_reg)
        else $error("result register busy during a scan");

    a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dist_vld_reg |-> (state_reg != ST_IDLE))
        else $error("distance word outside a scan");

    a_finish_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (rd_vld_reg || dist_vld_reg))
        else $error("scan pipeline emptied before the last entry");
`endif

endmodule

@@ rtl/core/nearest_palette_color_mapper_unit.sv @@
// nearest palette colour mapper
//
// pixel_in carries one word per item: command 0 writes red/green/blue into
// palette slot entry_index (slots at or beyond PALETTE_DEPTH are ignored) and
// gives no result; command 1 maps a pixel and gives one word on pixel_out with
// the nearest palette index and its squared rgb distance (lowest index on a tie)
// palette_count (apb register at byte address 0) sets how many slots are scanned;
// zero gives the grayscale value (r+g+b)/9 with distance 0
// each word is first registered in the input queue; the back then writes a palette
// load into the memory, sends a grayscale pixel straight to the result register, and
// scans the palette for any other pixel (one palette entry per cycle through the single memory
// read port, then the distance and compare stages); the next pixel is taken only when
// no scan runs and the result register is free, loads one per cycle while no scan runs
// a four-word queue keeps taking input while a result waits on pixel_out; when the
// receiver stalls, the result register holds and the next pixel waits in the queue
// reset clears the queue, the scan control, the result valid and palette_count;
// the palette memory is not cleared and must be loaded before it is used
module nearest_palette_color_mapper_unit
    import npcm_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // streaming channels
    npcm_in_if.sink               pixel_in,
    npcm_out_if.source            pixel_out
);

    logic [COUNT_W-1:0] palette_count_reg;
    logic [COUNT_W-1:0] palette_count_next;
    logic               cfg_write;

    npcm_op_t           head_op;
    logic               head_valid;
    logic               head_pop;

    // register word index sits above the byte offset
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        palette_count_next = palette_count_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_IDX_PALETTE_COUNT: palette_count_next = pwdata[COUNT_W-1:0];
                default:               palette_count_next = palette_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_IDX_PALETTE_COUNT: prdata = CFG_DATA_W'(palette_count_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_count_reg <= '0;
        end
        else
        begin
            palette_count_reg <= palette_count_next;
        end
    end

    // front: takes words, drops out-of-range loads, queues the rest
    npcm_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pixel_in),
        .head_op    (head_op),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    // back: palette memory, scan pipeline and result register
    npcm_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .palette_count (palette_count_reg),
        .head_op       (head_op),
        .head_valid    (head_valid),
        .head_pop      (head_pop),
        .pixel_out     (pixel_out)
    );

endmodule
